>>> rtl/yksr_pkg.sv
// yksr_pkg: types, codes, keyword tables and recognizer step functions
// for the yaml scalar kind resolver; no dependencies
package yksr_pkg;

    // integer recognizer states
    typedef enum logic [3:0] {
        IR_START   = 4'd0,
        IR_SIGN    = 4'd1,
        IR_DEC     = 4'd2,
        IR_ZERO    = 4'd3,
        IR_OCT_PRE = 4'd4,
        IR_OCT     = 4'd5,
        IR_HEX_PRE = 4'd6,
        IR_HEX     = 4'd7,
        IR_DEAD    = 4'd8
    } ir_state_t;

    // float recognizer states
    typedef enum logic [3:0] {
        FR_START    = 4'd0,
        FR_SIGN     = 4'd1,
        FR_LEAD_DOT = 4'd2,
        FR_INT      = 4'd3,
        FR_DOTTED   = 4'd4,
        FR_EXP_MARK = 4'd5,
        FR_EXP_SIGN = 4'd6,
        FR_EXP_DIG  = 4'd7,
        FR_DEAD     = 4'd8
    } fr_state_t;

    // resolved scalar kinds
    typedef enum logic [2:0] {
        KIND_STRING  = 3'd0,
        KIND_BOOL    = 3'd1,
        KIND_INTEGER = 3'd2,
        KIND_FLOAT   = 3'd3,
        KIND_NULL    = 3'd4,
        KIND_INVALID = 3'd5
    } kind_t;

    // explicit tag codes
    typedef enum logic [2:0] {
        TAG_NONE        = 3'd0,
        TAG_STR         = 3'd1,
        TAG_BOOL        = 3'd2,
        TAG_INT         = 3'd3,
        TAG_FLOAT       = 3'd4,
        TAG_NULL        = 3'd5,
        TAG_UNSUPPORTED = 3'd6
    } tag_t;

    // tag check status
    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_UNSUPPORTED = 2'd1,
        STATUS_MISMATCH    = 2'd2
    } status_t;

    localparam int KwCount = 16;

    localparam logic [15:0] KW_NULL_MASK = 16'h000F;
    localparam logic [15:0] KW_BOOL_MASK = 16'h03F0;
    localparam logic [15:0] KW_INF_MASK  = 16'h1C00;
    localparam logic [15:0] KW_NAN_MASK  = 16'hE000;

    // keyword text, first character in the top byte, zero padded
    localparam logic [39:0] KW_TEXT [KwCount] = '{
        {"~", 32'h0}, {"null", 8'h0}, {"Null", 8'h0}, {"NULL", 8'h0},
        {"true", 8'h0}, {"True", 8'h0}, {"TRUE", 8'h0},
        "false", "False", "FALSE",
        {".inf", 8'h0}, {".Inf", 8'h0}, {".INF", 8'h0},
        {".nan", 8'h0}, {".NaN", 8'h0}, {".NAN", 8'h0}
    };

    localparam logic [2:0] KW_LEN [KwCount] = '{
        3'd1, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5,
        3'd5, 3'd5, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
    };

    // one input beat as held in the input stage
    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
        logic       empty_scalar;
        logic       was_quoted;
        logic [2:0] tag_kind;
    } item_t;

    // recognizer view after the current byte
    typedef struct packed {
        logic        empty;
        logic [15:0] cand;
        logic [2:0]  nchars;
        ir_state_t   int_st;
        fr_state_t   flt_st;
    } scan_t;

    // one result beat
    typedef struct packed {
        logic [2:0] scalar_kind;
        logic [1:0] tag_status;
        logic       plain_ambiguous;
    } result_t;

    function automatic logic is_dec(logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_sign(logic [7:0] b);
        return (b == "+") || (b == "-");
    endfunction

    // character idx of keyword k, zero past the end
    function automatic logic [7:0] kw_char(int k, logic [2:0] idx);
        logic [39:0] t;
        t = KW_TEXT[k] << {idx, 3'b000};
        return t[39:32];
    endfunction

    function automatic ir_state_t int_next(ir_state_t s, logic [7:0] b);
        ir_state_t n;
        n = IR_DEAD;
        case (s)
            IR_START:
            begin
                if (b == "0")
                    n = IR_ZERO;
                else if (is_dec(b))
                    n = IR_DEC;
                else if (is_sign(b))
                    n = IR_SIGN;
            end
            IR_SIGN, IR_DEC:
            begin
                if (is_dec(b))
                    n = IR_DEC;
            end
            IR_ZERO:
            begin
                if (is_dec(b))
                    n = IR_DEC;
                else if (b == "o")
                    n = IR_OCT_PRE;
                else if (b == "x")
                    n = IR_HEX_PRE;
            end
            IR_OCT_PRE, IR_OCT:
            begin
                if (b inside {["0":"7"]})
                    n = IR_OCT;
            end
            IR_HEX_PRE, IR_HEX:
            begin
                if (b inside {["0":"9"], ["a":"f"], ["A":"F"]})
                    n = IR_HEX;
            end
            default:
            begin
                n = IR_DEAD;
            end
        endcase
        return n;
    endfunction

    function automatic fr_state_t flt_next(fr_state_t s, logic [7:0] b);
        fr_state_t n;
        logic      e;
        n = FR_DEAD;
        e = (b == "e") || (b == "E");
        case (s)
            FR_START, FR_SIGN:
            begin
                if ((s == FR_START) && is_sign(b))
                    n = FR_SIGN;
                else if (b == ".")
                    n = FR_LEAD_DOT;
                else if (is_dec(b))
                    n = FR_INT;
            end
            FR_LEAD_DOT:
            begin
                if (is_dec(b))
                    n = FR_DOTTED;
            end
            FR_INT:
            begin
                if (is_dec(b))
                    n = FR_INT;
                else if (b == ".")
                    n = FR_DOTTED;
                else if (e)
                    n = FR_EXP_MARK;
            end
            FR_DOTTED:
            begin
                if (is_dec(b))
                    n = FR_DOTTED;
                else if (e)
                    n = FR_EXP_MARK;
            end
            FR_EXP_MARK, FR_EXP_SIGN, FR_EXP_DIG:
            begin
                if ((s == FR_EXP_MARK) && is_sign(b))
                    n = FR_EXP_SIGN;
                else if (is_dec(b))
                    n = FR_EXP_DIG;
            end
            default:
            begin
                n = FR_DEAD;
            end
        endcase
        return n;
    endfunction

endpackage

>>> rtl/yksr_if.sv
// yksr_if: valid/ready channels for scalar text beats and resolved results
// no dependencies
interface yksr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last_byte;
    logic       empty_scalar;
    logic       was_quoted;
    logic [2:0] tag_kind;

    modport source (
        output valid, text_byte, last_byte, empty_scalar, was_quoted, tag_kind,
        input  ready
    );
    modport sink (
        input  valid, text_byte, last_byte, empty_scalar, was_quoted, tag_kind,
        output ready
    );
endinterface

interface yksr_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] scalar_kind;
    logic [1:0] tag_status;
    logic       plain_ambiguous;

    modport source (
        output valid, scalar_kind, tag_status, plain_ambiguous,
        input  ready
    );
    modport sink (
        input  valid, scalar_kind, tag_status, plain_ambiguous,
        output ready
    );
endinterface

>>> rtl/yksr_scan.sv
// yksr_scan: per-scalar recognizer state (position, keyword candidates,
// sign, integer and float automata); uses yksr_pkg
module yksr_scan (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  yksr_pkg::item_t item,
    output yksr_pkg::scan_t scan
);

    logic [2:0]          pos_reg;
    logic [2:0]          pos_next;
    logic [15:0]         cand_reg;
    logic [15:0]         cand_next;
    logic                sign_reg;
    logic                sign_next;
    yksr_pkg::ir_state_t int_reg;
    yksr_pkg::ir_state_t int_next;
    yksr_pkg::fr_state_t flt_reg;
    yksr_pkg::fr_state_t flt_next;
    logic [2:0]          idx;
    logic                ends;

    // candidate, sign, position and automaton update for this byte
    always_comb
    begin
        idx       = pos_reg - {2'b00, sign_reg};
        sign_next = sign_reg;
        cand_next = cand_reg;
        if ((pos_reg == 3'd0) && yksr_pkg::is_sign(item.text_byte))
        begin
            sign_next = 1'b1;
            cand_next = cand_reg & yksr_pkg::KW_INF_MASK;
        end
        else if (pos_reg == 3'd7)
        begin
            cand_next = '0;
        end
        else
        begin
            for (int k = 0; k < yksr_pkg::KwCount; k++)
            begin
                if ((idx >= yksr_pkg::KW_LEN[k]) ||
                    (yksr_pkg::kw_char(k, idx) != item.text_byte))
                    cand_next[k] = 1'b0;
            end
        end
        pos_next = (pos_reg == 3'd7) ? 3'd7 : pos_reg + 3'd1;
        int_next = yksr_pkg::int_next(int_reg, item.text_byte);
        flt_next = yksr_pkg::flt_next(flt_reg, item.text_byte);
    end

    // view handed to the resolver
    always_comb
    begin
        scan.empty  = item.empty_scalar;
        scan.cand   = cand_next;
        scan.nchars = pos_next - {2'b00, sign_next};
        scan.int_st = int_next;
        scan.flt_st = flt_next;
    end

    assign ends = item.last_byte | item.empty_scalar;

    // state registers, cleared when a scalar ends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 3'd0;
            cand_reg <= '1;
            sign_reg <= 1'b0;
            int_reg  <= yksr_pkg::IR_START;
            flt_reg  <= yksr_pkg::FR_START;
        end
        else if (step)
        begin
            if (ends)
            begin
                pos_reg  <= 3'd0;
                cand_reg <= '1;
                sign_reg <= 1'b0;
                int_reg  <= yksr_pkg::IR_START;
                flt_reg  <= yksr_pkg::FR_START;
            end
            else
            begin
                pos_reg  <= pos_next;
                cand_reg <= cand_next;
                sign_reg <= sign_next;
                int_reg  <= int_next;
                flt_reg  <= flt_next;
            end
        end
    end

endmodule

>>> rtl/yksr_resolve.sv
// yksr_resolve: turns the recognizer view plus quoting and tag into a
// kind, tag status and ambiguity flag; uses yksr_pkg
module yksr_resolve (
    input  yksr_pkg::scan_t   scan,
    input  logic              was_quoted,
    input  logic [2:0]        tag_kind,
    output yksr_pkg::result_t result
);

    logic [15:0]      kw_hit;
    logic             is_null;
    logic             is_bool;
    logic             is_int;
    logic             is_flt;
    yksr_pkg::kind_t  plain;
    yksr_pkg::kind_t  kind;
    yksr_pkg::status_t status;

    // keywords whose full length was matched
    always_comb
    begin
        for (int k = 0; k < yksr_pkg::KwCount; k++)
            kw_hit[k] = !scan.empty && scan.cand[k] && (yksr_pkg::KW_LEN[k] == scan.nchars);
    end

    // plain reading
    always_comb
    begin
        is_null = scan.empty || (|(kw_hit & yksr_pkg::KW_NULL_MASK));
        is_bool = |(kw_hit & yksr_pkg::KW_BOOL_MASK);
        is_int  = !scan.empty && (scan.int_st inside {yksr_pkg::IR_DEC, yksr_pkg::IR_ZERO,
                                                      yksr_pkg::IR_OCT, yksr_pkg::IR_HEX});
        is_flt  = (!scan.empty && (scan.flt_st inside {yksr_pkg::FR_DOTTED,
                                                       yksr_pkg::FR_EXP_DIG})) ||
                  (|(kw_hit & (yksr_pkg::KW_INF_MASK | yksr_pkg::KW_NAN_MASK)));
        if (is_null)
            plain = yksr_pkg::KIND_NULL;
        else if (is_bool)
            plain = yksr_pkg::KIND_BOOL;
        else if (is_int)
            plain = yksr_pkg::KIND_INTEGER;
        else if (is_flt)
            plain = yksr_pkg::KIND_FLOAT;
        else
            plain = yksr_pkg::KIND_STRING;
    end

    // explicit tag overrides and is checked against the text
    always_comb
    begin
        status = yksr_pkg::STATUS_OK;
        case (tag_kind)
            yksr_pkg::TAG_NONE:
            begin
                kind = was_quoted ? yksr_pkg::KIND_STRING : plain;
            end
            yksr_pkg::TAG_STR:
            begin
                kind = yksr_pkg::KIND_STRING;
            end
            yksr_pkg::TAG_BOOL:
            begin
                kind = yksr_pkg::KIND_BOOL;
                if (!is_bool)
                    status = yksr_pkg::STATUS_MISMATCH;
            end
            yksr_pkg::TAG_INT:
            begin
                kind = yksr_pkg::KIND_INTEGER;
                if (!is_int)
                    status = yksr_pkg::STATUS_MISMATCH;
            end
            yksr_pkg::TAG_FLOAT:
            begin
                kind = yksr_pkg::KIND_FLOAT;
                if (!(is_int || is_flt))
                    status = yksr_pkg::STATUS_MISMATCH;
            end
            yksr_pkg::TAG_NULL:
            begin
                kind = yksr_pkg::KIND_NULL;
                if (!is_null)
                    status = yksr_pkg::STATUS_MISMATCH;
            end
            default:
            begin
                kind   = yksr_pkg::KIND_INVALID;
                status = yksr_pkg::STATUS_UNSUPPORTED;
            end
        endcase
    end

    assign result.scalar_kind     = kind;
    assign result.tag_status      = status;
    assign result.plain_ambiguous = (plain != yksr_pkg::KIND_STRING);

endmodule

>>> rtl/yaml_scalar_kind_resolver.sv
// yaml_scalar_kind_resolver: top level; input stage register, recognizer
// and resolver, result register; uses yksr_pkg, yksr_if, yksr_scan, yksr_resolve
// an ending beat is staged, then its result is held in the result register
// throughput: one text beat per cycle, set by the single-byte recognizer step, but
// a waiting result does not block non-ending beats; an ending beat waits for
// the result register to free up
// reset: asynchronous active low, empties both stages and restarts the recognizer
module yaml_scalar_kind_resolver (
    input logic        clk,
    input logic        rst_n,
    yksr_in_if.sink    item,
    yksr_out_if.source result
);

    logic              stage_valid_reg;
    logic              stage_valid_next;
    yksr_pkg::item_t   stage_item_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    yksr_pkg::result_t out_result_reg;
    yksr_pkg::result_t resolved;
    yksr_pkg::scan_t   scan;
    logic              stage_ends;
    logic              advance;
    logic              in_take;

    // stage handshake
    assign stage_ends = stage_item_reg.last_byte | stage_item_reg.empty_scalar;
    assign advance    = stage_valid_reg &&
                        (!stage_ends || !out_valid_reg || result.ready);
    assign item.ready = !stage_valid_reg || advance;
    assign in_take    = item.valid && item.ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_take)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance && stage_ends)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    yksr_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (stage_item_reg),
        .scan  (scan)
    );

    yksr_resolve u_resolve (
        .scan       (scan),
        .was_quoted (stage_item_reg.was_quoted),
        .tag_kind   (stage_item_reg.tag_kind),
        .result     (resolved)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stage_item_reg.text_byte    <= item.text_byte;
            stage_item_reg.last_byte    <= item.last_byte;
            stage_item_reg.empty_scalar <= item.empty_scalar;
            stage_item_reg.was_quoted   <= item.was_quoted;
            stage_item_reg.tag_kind     <= item.tag_kind;
        end
        if (advance && stage_ends)
            out_result_reg <= resolved;
    end

    // result beat
    assign result.valid           = out_valid_reg;
    assign result.scalar_kind     = out_result_reg.scalar_kind;
    assign result.tag_status      = out_result_reg.tag_status;
    assign result.plain_ambiguous = out_result_reg.plain_ambiguous;

endmodule

>>> bench/yaml_scalar_kind_resolver_test.sv
// yaml_scalar_kind_resolver_test: self-checking bench for the scalar kind resolver
// drives text beats, predicts each resolution in-bench and checks every result beat
// depends on rtl/yksr_pkg.sv, rtl/yksr_if.sv and rtl/yaml_scalar_kind_resolver.sv
`timescale 1ns / 100ps

module yaml_scalar_kind_resolver_test;

    import yksr_pkg::*;

    // tag code above the unsupported one, still reads as unsupported
    localparam logic [2:0] TagReserved = 3'd7;

    // receiver stall patterns
    typedef enum int {
        RX_OPEN    = 0,
        RX_COIN    = 1,
        RX_TRICKLE = 2,
        RX_LONG    = 3
    } rx_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    yksr_in_if  text_ch ();
    yksr_out_if kind_ch ();

    yaml_scalar_kind_resolver i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (text_ch),
        .result (kind_ch)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // keyword spellings, bit k of the candidate mask follows entry k
    string kw_words [16] = '{
        "~", "null", "Null", "NULL", "true", "True", "TRUE", "false", "False", "FALSE",
        ".inf", ".Inf", ".INF", ".nan", ".NaN", ".NAN"
    };
    string odd_chars = "0789afAFgGxXoOeE.+-~ _";

    // recognizer shadow state
    logic [2:0]  scan_pos;
    logic [15:0] scan_cand;
    logic        scan_signed;
    ir_state_t   scan_int;
    fr_state_t   scan_flt;

    result_t     pending_resolutions [$];
    logic [7:0]  text_buf [$];

    int beats_sent;
    int scalars_sent;
    int results_seen;
    int mismatches;
    int burst_left;
    int kind_tally [8];

    rx_mode_t rx_mode;
    int       rx_count;
    int       rx_hold;

    function automatic bit digit_char(logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic bit sign_char(logic [7:0] b);
        return (b == "+") || (b == "-");
    endfunction

    // integer recognizer: signed decimal, 0o octal, 0x hex
    function automatic ir_state_t int_step(ir_state_t s, logic [7:0] b);
        ir_state_t n;
        n = IR_DEAD;
        case (s)
            IR_START:
            begin
                if (b == "0")
                    n = IR_ZERO;
                else if (digit_char(b))
                    n = IR_DEC;
                else if (sign_char(b))
                    n = IR_SIGN;
            end
            IR_SIGN, IR_DEC:
            begin
                if (digit_char(b))
                    n = IR_DEC;
            end
            IR_ZERO:
            begin
                if (digit_char(b))
                    n = IR_DEC;
                else if (b == "o")
                    n = IR_OCT_PRE;
                else if (b == "x")
                    n = IR_HEX_PRE;
            end
            IR_OCT_PRE, IR_OCT:
            begin
                if ((b >= "0") && (b <= "7"))
                    n = IR_OCT;
            end
            IR_HEX_PRE, IR_HEX:
            begin
                if (digit_char(b) || ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F")))
                    n = IR_HEX;
            end
            default:
                n = IR_DEAD;
        endcase
        return n;
    endfunction

    // float recognizer: mantissa with dot and/or exponent
    function automatic fr_state_t flt_step(fr_state_t s, logic [7:0] b);
        fr_state_t n;
        bit        exp_char;
        n = FR_DEAD;
        exp_char = (b == "e") || (b == "E");
        case (s)
            FR_START:
            begin
                if (sign_char(b))
                    n = FR_SIGN;
                else if (b == ".")
                    n = FR_LEAD_DOT;
                else if (digit_char(b))
                    n = FR_INT;
            end
            FR_SIGN:
            begin
                if (b == ".")
                    n = FR_LEAD_DOT;
                else if (digit_char(b))
                    n = FR_INT;
            end
            FR_LEAD_DOT:
            begin
                if (digit_char(b))
                    n = FR_DOTTED;
            end
            FR_INT:
            begin
                if (digit_char(b))
                    n = FR_INT;
                else if (b == ".")
                    n = FR_DOTTED;
                else if (exp_char)
                    n = FR_EXP_MARK;
            end
            FR_DOTTED:
            begin
                if (digit_char(b))
                    n = FR_DOTTED;
                else if (exp_char)
                    n = FR_EXP_MARK;
            end
            FR_EXP_MARK:
            begin
                if (sign_char(b))
                    n = FR_EXP_SIGN;
                else if (digit_char(b))
                    n = FR_EXP_DIG;
            end
            FR_EXP_SIGN, FR_EXP_DIG:
            begin
                if (digit_char(b))
                    n = FR_EXP_DIG;
            end
            default:
                n = FR_DEAD;
        endcase
        return n;
    endfunction

    task automatic clear_scan();
        scan_pos    = 3'd0;
        scan_cand   = 16'hFFFF;
        scan_signed = 1'b0;
        scan_int    = IR_START;
        scan_flt    = FR_START;
    endtask

    // append one character to the scalar text being built
    task automatic append_char(logic [7:0] c);
        text_buf = {text_buf, c};
    endtask

    // advance the shadow recognizers by one text byte
    task automatic scan_text_byte(logic [7:0] b);
        int idx;
        if ((scan_pos == 3'd0) && sign_char(b))
        begin
            scan_signed = 1'b1;
            scan_cand   = scan_cand & KW_INF_MASK;
        end
        else if (scan_pos == 3'd7)
        begin
            scan_cand = 16'h0000;
        end
        else
        begin
            idx = int'(scan_pos) - int'(scan_signed);
            for (int k = 0; k < 16; k++)
            begin
                if ((idx >= kw_words[k].len()) || (kw_words[k][idx] != b))
                    scan_cand[k] = 1'b0;
            end
        end
        scan_int = int_step(scan_int, b);
        scan_flt = flt_step(scan_flt, b);
        if (scan_pos != 3'd7)
            scan_pos = scan_pos + 3'd1;
    endtask

    // kind, tag check and plain reading of the scalar held in the shadow state
    function automatic result_t resolve_scalar(logic emp, logic quoted, logic [2:0] tg);
        logic [15:0] hit;
        int          nch;
        bit          is_null;
        bit          is_bool;
        bit          is_int;
        bit          is_flt;
        kind_t       plain_kind;
        kind_t       kind;
        status_t     status;
        result_t     r;
        hit = 16'h0000;
        if (!emp)
        begin
            nch = int'(scan_pos) - int'(scan_signed);
            for (int k = 0; k < 16; k++)
            begin
                if (scan_cand[k] && (kw_words[k].len() == nch))
                    hit[k] = 1'b1;
            end
        end
        is_null = emp || ((hit & KW_NULL_MASK) != 16'h0000);
        is_bool = !emp && ((hit & KW_BOOL_MASK) != 16'h0000);
        is_int  = !emp && ((scan_int == IR_DEC) || (scan_int == IR_ZERO) ||
                           (scan_int == IR_OCT) || (scan_int == IR_HEX));
        is_flt  = !emp && ((scan_flt == FR_DOTTED) || (scan_flt == FR_EXP_DIG) ||
                           ((hit & (KW_INF_MASK | KW_NAN_MASK)) != 16'h0000));

        if (is_null)
            plain_kind = KIND_NULL;
        else if (is_bool)
            plain_kind = KIND_BOOL;
        else if (is_int)
            plain_kind = KIND_INTEGER;
        else if (is_flt)
            plain_kind = KIND_FLOAT;
        else
            plain_kind = KIND_STRING;

        // explicit tag overrides the plain reading and is checked against the text
        status = STATUS_OK;
        case (tg)
            TAG_NONE:
                kind = quoted ? KIND_STRING : plain_kind;
            TAG_STR:
                kind = KIND_STRING;
            TAG_BOOL:
            begin
                kind   = KIND_BOOL;
                status = is_bool ? STATUS_OK : STATUS_MISMATCH;
            end
            TAG_INT:
            begin
                kind   = KIND_INTEGER;
                status = is_int ? STATUS_OK : STATUS_MISMATCH;
            end
            TAG_FLOAT:
            begin
                kind   = KIND_FLOAT;
                status = (is_int || is_flt) ? STATUS_OK : STATUS_MISMATCH;
            end
            TAG_NULL:
            begin
                kind   = KIND_NULL;
                status = is_null ? STATUS_OK : STATUS_MISMATCH;
            end
            default:
            begin
                kind   = KIND_INVALID;
                status = STATUS_UNSUPPORTED;
            end
        endcase
        r.scalar_kind     = kind;
        r.tag_status      = status;
        r.plain_ambiguous = (plain_kind != KIND_STRING);
        return r;
    endfunction

    // update the shadow state for one accepted beat, queue a resolution on scalar end
    task automatic track_beat(logic [7:0] b, logic lst, logic emp, logic quoted, logic [2:0] tg);
        result_t r;
        if (emp)
        begin
            r = resolve_scalar(1'b1, quoted, tg);
            pending_resolutions = {pending_resolutions, r};
            kind_tally[r.scalar_kind]++;
            clear_scan();
        end
        else
        begin
            scan_text_byte(b);
            if (lst)
            begin
                r = resolve_scalar(1'b0, quoted, tg);
                pending_resolutions = {pending_resolutions, r};
                kind_tally[r.scalar_kind]++;
                clear_scan();
            end
        end
    endtask

    // drive one beat, with random bursts and gaps, and wait for acceptance
    task automatic send_beat(logic [7:0] b, logic lst, logic emp, logic quoted, logic [2:0] tg);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 7);
            if (gap != 0)
            begin
                text_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        text_ch.valid        <= 1'b1;
        text_ch.text_byte    <= b;
        text_ch.last_byte    <= lst;
        text_ch.empty_scalar <= emp;
        text_ch.was_quoted   <= quoted;
        text_ch.tag_kind     <= tg;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        track_beat(b, lst, emp, quoted, tg);
        beats_sent++;
    endtask

    // send the text in text_buf as one scalar; cut ends it with an empty beat instead
    task automatic send_scalar(logic quoted, logic [2:0] tg, bit cut);
        int n;
        n = text_buf.size();
        for (int i = 0; i < n; i++)
        begin
            if ((i == n - 1) && !cut)
                send_beat(text_buf[i], 1'b1, 1'b0, quoted, tg);
            else
                send_beat(text_buf[i], 1'b0, 1'b0, 1'($urandom_range(0, 1)),
                          3'($urandom_range(0, 7)));
        end
        if ((n == 0) || cut)
            send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, quoted, tg);
        text_buf.delete();
        scalars_sent++;
    endtask

    // stop sending until every pending resolution has come back
    task automatic hold_until_drained();
        @(negedge clk);
        text_ch.valid <= 1'b0;
        while (pending_resolutions.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_word(string s);
        for (int i = 0; i < s.len(); i++)
            append_char(s[i]);
    endtask

    task automatic add_sign();
        append_char($urandom_range(0, 1) ? "+" : "-");
    endtask

    task automatic add_digits(int n, int radix);
        int v;
        for (int i = 0; i < n; i++)
        begin
            v = $urandom_range(0, radix - 1);
            if (v < 10)
                append_char(8'("0" + v));
            else if ($urandom_range(0, 1))
                append_char(8'("a" + v - 10));
            else
                append_char(8'("A" + v - 10));
        end
    endtask

    task automatic mutate_one();
        if (text_buf.size() != 0)
            text_buf[$urandom_range(0, text_buf.size() - 1)] =
                odd_chars[$urandom_range(0, odd_chars.len() - 1)];
    endtask

    function automatic logic [2:0] pick_tag();
        if ($urandom_range(0, 1))
            return TAG_NONE;
        return 3'($urandom_range(0, 7));
    endfunction

    function automatic logic pick_quote();
        return ($urandom_range(0, 4) == 0);
    endfunction

    function automatic bit pick_cut();
        return ($urandom_range(0, 15) == 0);
    endfunction

    // keywords, optionally signed, sometimes bent out of shape
    task automatic build_keyword_text();
        int p;
        if ($urandom_range(0, 3) == 0)
            add_sign();
        add_word(kw_words[$urandom_range(0, 15)]);
        p = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 7))
            0:
                mutate_one();
            1:
            begin
                if (((text_buf[p] >= "a") && (text_buf[p] <= "z")) ||
                    ((text_buf[p] >= "A") && (text_buf[p] <= "Z")))
                    text_buf[p] = text_buf[p] ^ 8'h20;
            end
            2:
                append_char(odd_chars[$urandom_range(0, odd_chars.len() - 1)]);
            3:
            begin
                if (text_buf.size() > 1)
                    text_buf.delete(text_buf.size() - 1);
            end
            default:
                ;
        endcase
    endtask

    // integer and float spellings, fragments and near misses
    task automatic build_number_text();
        int shape;
        shape = $urandom_range(0, 7);
        case (shape)
            0, 6:
            begin
                if ($urandom_range(0, 1))
                    add_sign();
                add_digits($urandom_range(1, 6), 10);
            end
            1:
            begin
                add_word("0o");
                add_digits($urandom_range(0, 4), 8);
            end
            2:
            begin
                add_word("0x");
                add_digits($urandom_range(0, 4), 16);
            end
            3, 7:
            begin
                if ($urandom_range(0, 1))
                    add_sign();
                add_digits($urandom_range(0, 3), 10);
                if ($urandom_range(0, 3) != 0)
                    add_word(".");
                add_digits($urandom_range(0, 3), 10);
                if ($urandom_range(0, 1))
                begin
                    add_word($urandom_range(0, 1) ? "e" : "E");
                    if ($urandom_range(0, 1))
                        add_sign();
                    add_digits($urandom_range(0, 2), 10);
                end
            end
            4:
            begin
                add_word("0");
                add_digits($urandom_range(0, 3), 10);
            end
            default:
            begin
                case ($urandom_range(0, 5))
                    0: add_word("0X1");
                    1: add_word("0O7");
                    2: add_word("-0x1");
                    3: add_word("1e");
                    4: add_word("+.");
                    default: add_word("1e+");
                endcase
            end
        endcase
        if (shape >= 6)
            mutate_one();
    endtask

    // raw bytes, long runs and empty scalars
    task automatic build_noise_text();
        case ($urandom_range(0, 3))
            0:
            begin
                repeat ($urandom_range(1, 12))
                    append_char(8'($urandom_range(0, 255)));
            end
            1:
            begin
                if ($urandom_range(0, 1))
                    add_sign();
                add_digits($urandom_range(8, 14), 10);
                if ($urandom_range(0, 1))
                    mutate_one();
            end
            2:
                ;
            default:
            begin
                repeat ($urandom_range(1, 6))
                    append_char(odd_chars[$urandom_range(0, odd_chars.len() - 1)]);
            end
        endcase
    endtask

    // hand-picked scalars: field extremes, every tag and each corner of the resolver
    task automatic test_directed();
        // empty scalar with an all-ones byte and the reserved tag code
        send_beat(8'hFF, 1'b1, 1'b1, 1'b1, TagReserved);
        // quoted null keyword stays a string but reads ambiguous
        add_word("~");
        send_scalar(1'b1, TAG_NONE, 1'b0);
        // bytes thrown away by an empty beat mid-scalar
        add_word("a");
        send_scalar(1'b0, TAG_NULL, 1'b1);
        // signed float under the unsupported tag
        add_word("-1.5");
        send_scalar(1'b0, TAG_UNSUPPORTED, 1'b0);
        add_word("0o7");
        send_scalar(1'b0, TAG_INT, 1'b0);
        add_word("True");
        send_scalar(1'b0, TAG_BOOL, 1'b0);
        // all-zero byte forced to string
        append_char(8'h00);
        send_scalar(1'b0, TAG_STR, 1'b0);
        // lone dot does not fit a float tag
        add_word(".");
        send_scalar(1'b0, TAG_FLOAT, 1'b0);
        // position count saturates, integer recognizer keeps going
        add_word("123456789");
        send_scalar(1'b0, TAG_NONE, 1'b0);
    endtask

    task automatic test_keyword_text();
        int goal;
        goal = beats_sent + 260;
        while (beats_sent < goal)
        begin
            build_keyword_text();
            send_scalar(pick_quote(), pick_tag(), pick_cut());
        end
    endtask

    task automatic test_number_text();
        int goal;
        goal = beats_sent + 300;
        while (beats_sent < goal)
        begin
            build_number_text();
            send_scalar(pick_quote(), pick_tag(), pick_cut());
        end
    endtask

    task automatic test_noise_text();
        int goal;
        goal = beats_sent + 140;
        while (beats_sent < goal)
        begin
            build_noise_text();
            send_scalar(pick_quote(), pick_tag(), pick_cut());
        end
    endtask

    task automatic test_mixed_text();
        int goal;
        goal = beats_sent + 150;
        while (beats_sent < goal)
        begin
            case ($urandom_range(0, 2))
                0: build_keyword_text();
                1: build_number_text();
                default: build_noise_text();
            endcase
            send_scalar(pick_quote(), pick_tag(), pick_cut());
        end
    endtask

    function automatic void check_field(string name, int want_v, int got_v);
        if (want_v != got_v)
        begin
            if (mismatches < 10)
                $display("result %0d: %s expected %0d, got %0d", results_seen, name, want_v, got_v);
            mismatches++;
        end
    endfunction

    // result checker, sampled at the rising edge
    result_t want;
    always @(posedge clk)
    begin
        if (rst_n && kind_ch.valid && kind_ch.ready)
        begin
            if (pending_resolutions.size() == 0)
            begin
                if (mismatches < 10)
                    $display("result %0d arrived with no scalar pending", results_seen);
                mismatches++;
            end
            else
            begin
                want = pending_resolutions.pop_front();
                check_field("scalar_kind", want.scalar_kind, kind_ch.scalar_kind);
                check_field("tag_status", want.tag_status, kind_ch.tag_status);
                check_field("plain_ambiguous", want.plain_ambiguous, kind_ch.plain_ambiguous);
            end
            results_seen++;
        end
    end

    // receiver stall patterns, each held for a random stretch
    initial
    begin
        kind_ch.ready = 1'b0;
        rx_count = 0;
        rx_hold  = 0;
        forever
        begin
            @(negedge clk);
            if (rx_count == 0)
            begin
                rx_mode  = rx_mode_t'($urandom_range(0, 3));
                rx_count = $urandom_range(20, 80);
            end
            rx_count--;
            case (rx_mode)
                RX_OPEN:
                    kind_ch.ready <= 1'b1;
                RX_COIN:
                    kind_ch.ready <= 1'($urandom_range(0, 1));
                RX_TRICKLE:
                    kind_ch.ready <= ((rx_count % 4) == 0);
                default:
                begin
                    if (rx_hold == 0)
                    begin
                        kind_ch.ready <= 1'b1;
                        rx_hold = $urandom_range(2, 14);
                    end
                    else
                    begin
                        kind_ch.ready <= 1'b0;
                        rx_hold--;
                    end
                end
            endcase
        end
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // test sequence
    initial
    begin
        rst_n                = 1'b0;
        text_ch.valid        = 1'b0;
        text_ch.text_byte    = 8'h00;
        text_ch.last_byte    = 1'b0;
        text_ch.empty_scalar = 1'b0;
        text_ch.was_quoted   = 1'b0;
        text_ch.tag_kind     = TAG_NONE;
        beats_sent   = 0;
        scalars_sent = 0;
        results_seen = 0;
        mismatches   = 0;
        burst_left   = 0;
        foreach (kind_tally[i])
            kind_tally[i] = 0;
        clear_scan();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        hold_until_drained();
        test_keyword_text();
        hold_until_drained();
        test_number_text();
        test_noise_text();
        hold_until_drained();
        test_mixed_text();
        hold_until_drained();
        repeat (8) @(posedge clk);

        $display("sent %0d scalars in %0d text beats, checked %0d results, %0d mismatches",
                 scalars_sent, beats_sent, results_seen, mismatches);
        $display("kinds: string %0d, bool %0d, integer %0d, float %0d, null %0d, invalid %0d",
                 kind_tally[KIND_STRING], kind_tally[KIND_BOOL], kind_tally[KIND_INTEGER],
                 kind_tally[KIND_FLOAT], kind_tally[KIND_NULL], kind_tally[KIND_INVALID]);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/yksr_pkg.sv
rtl/yksr_if.sv
rtl/yksr_scan.sv
rtl/yksr_resolve.sv
rtl/yaml_scalar_kind_resolver.sv
bench/yaml_scalar_kind_resolver_test.sv
